@@ sv/waypoint_shortest_path_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Waypoint shortest path unit assertion macros
// Clocked, reset-gated property shorthands used at the top level.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_SHORTEST_PATH_UNIT_MACROS_SVH
`define WAYPOINT_SHORTEST_PATH_UNIT_MACROS_SVH

// Same-cycle implication
`define WSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define WSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// Waypoint shortest path package
// Payload types, codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int unsigned MAX_NODES    = 512;
    localparam int unsigned MAX_EDGES    = 16;
    localparam int unsigned NODE_W       = 9;
    localparam int unsigned LEN_W        = 10;
    localparam int unsigned FILL_W       = 5;
    localparam int unsigned SLOT_W       = 13;
    localparam int unsigned COST_W       = 32;
    localparam int unsigned VISIT_W      = 16;
    localparam int unsigned VIS50_W      = 22;
    localparam int unsigned VISIT_WEIGHT = 50;

    // request functions
    localparam logic [2:0] FUNC_WRITE_NODE = 3'd0;
    localparam logic [2:0] FUNC_APPEND     = 3'd1;
    localparam logic [2:0] FUNC_BUMP       = 3'd2;
    localparam logic [2:0] FUNC_FIND       = 3'd3;
    localparam logic [2:0] FUNC_READ_PATH  = 3'd4;

    // key codes
    localparam logic [1:0] KEY_NONE   = 2'd0;
    localparam logic [1:0] KEY_BLUE   = 2'd1;
    localparam logic [1:0] KEY_RED    = 2'd2;
    localparam logic [1:0] KEY_YELLOW = 2'd3;

    typedef struct packed {
        logic [2:0]         func;
        logic [NODE_W-1:0]  node_index;
        logic [NODE_W-1:0]  neighbor_index;
        logic [10:0]        edge_length;
        logic               door_flag;
        logic [1:0]         key_needed;
        logic [VISIT_W-1:0] visit_init;
        logic [2:0]         held_keys;
        logic [NODE_W-1:0]  start_node;
        logic [NODE_W-1:0]  goal_node;
        logic [NODE_W-1:0]  path_index;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  path_length;
        logic [NODE_W-1:0] path_node;
        logic              entry_valid;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_APPEND, ST_BUMP, ST_PATH_LOAD, ST_CLEAR, ST_SEED,
        ST_POP_RD, ST_POP, ST_ULOAD, ST_EDGE_RD, ST_EDGE_TAKE, ST_EDGE_MUL,
        ST_EDGE_ADD, ST_EDGE_UPD, ST_GOAL_RD, ST_GOAL_CHK, ST_CNT, ST_CNT_LOAD,
        ST_PW_INIT, ST_PW, ST_PW_LOAD, ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CAPTURE, OP_NODE_WR, OP_APPEND, OP_BUMP, OP_PATH_LOAD,
        OP_SAME_WR, OP_CLR_INIT, OP_CLR, OP_SEED, OP_POP, OP_ULOAD, OP_EDGE_SKIP,
        OP_EDGE_TAKE, OP_EDGE_MUL, OP_EDGE_ADD, OP_EDGE_UPD, OP_WALK_INIT, OP_CNT,
        OP_CNT_LOAD, OP_PW_INIT, OP_PW, OP_PW_LOAD, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       query_ok;
        logic       same_node;
        logic       clr_last;
        logic       q_empty;
        logic       is_goal;
        logic       edges_done;
        logic       v_out;
        logic       goal_valid;
        logic       walk_stop;
        logic       pw_last;
        logic       out_free;
    } dp_status_t;

endpackage

@@ sv/waypoint_shortest_path_unit.sv @@
// Write node: capture, decode with the memory write, then the response state.
// Append / bump / path read: capture, decode, the operation, then the response state.
// Path query: label clearing to the node limit, search per queued node and edge, path walk.
// One request is in flight at a time; the single-port graph memories set the rate.
// Reset: asynchronous, active low; clears node_count, stored path length and handshakes.
// Graph and search memories hold no reset value and are valid once written.
// ----------------------------------------------------------------------------
// Waypoint shortest path unit
// Top level: APB node count register, controller and datapath.
// ----------------------------------------------------------------------------
`include "waypoint_shortest_path_unit_macros.svh"

module waypoint_shortest_path_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  wsp_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output wsp_pkg::rsp_t rsp_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import wsp_pkg::*;

    logic [9:0] node_count_reg;
    ctl_cmd_t   cmd;
    dp_status_t status;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            node_count_reg <= pwdata[9:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {22'd0, node_count_reg};

    wsp_controller u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    wsp_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_data   (req_data),
        .node_count (node_count_reg),
        .status     (status),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

    // checks
    `WSP_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accept not followed by busy")
    `WSP_ASSERT_IMP(a_len_range, rsp_valid, rsp_data.path_length <= 10'd512, "path length out of range")
    `WSP_ASSERT_IMP(a_entry_not_found, rsp_valid && rsp_data.entry_valid, !rsp_data.found, "entry with found")

endmodule

@@ sv/wsp_controller.sv @@
// ----------------------------------------------------------------------------
// Waypoint shortest path controller
// Sequences each request through datapath micro-operations.
// ----------------------------------------------------------------------------
module wsp_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  wsp_pkg::dp_status_t status,
    output wsp_pkg::ctl_cmd_t   cmd
);
    import wsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (status.func)
                    FUNC_APPEND:    state_next = ST_APPEND;
                    FUNC_BUMP:      state_next = ST_BUMP;
                    FUNC_READ_PATH: state_next = ST_PATH_LOAD;
                    FUNC_FIND:
                    begin
                        if (status.query_ok && !status.same_node)
                            state_next = ST_CLEAR;
                        else
                            state_next = ST_RESP;
                    end
                    default:        state_next = ST_RESP;
                endcase
            end
            ST_APPEND, ST_BUMP, ST_PATH_LOAD: state_next = ST_RESP;
            ST_CLEAR:
            begin
                if (status.clr_last)
                    state_next = ST_SEED;
            end
            ST_SEED:      state_next = ST_POP_RD;
            ST_POP_RD:    state_next = status.q_empty ? ST_GOAL_RD : ST_POP;
            ST_POP:       state_next = status.is_goal ? ST_GOAL_RD : ST_ULOAD;
            ST_ULOAD:     state_next = ST_EDGE_RD;
            ST_EDGE_RD:   state_next = status.edges_done ? ST_POP_RD : ST_EDGE_TAKE;
            ST_EDGE_TAKE: state_next = status.v_out ? ST_EDGE_RD : ST_EDGE_MUL;
            ST_EDGE_MUL:  state_next = ST_EDGE_ADD;
            ST_EDGE_ADD:  state_next = ST_EDGE_UPD;
            ST_EDGE_UPD:  state_next = ST_EDGE_RD;
            ST_GOAL_RD:   state_next = ST_GOAL_CHK;
            ST_GOAL_CHK:  state_next = status.goal_valid ? ST_CNT : ST_RESP;
            ST_CNT:       state_next = status.walk_stop ? ST_PW_INIT : ST_CNT_LOAD;
            ST_CNT_LOAD:  state_next = ST_CNT;
            ST_PW_INIT:   state_next = ST_PW;
            ST_PW:        state_next = status.pw_last ? ST_RESP : ST_PW_LOAD;
            ST_PW_LOAD:   state_next = ST_PW;
            ST_RESP:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      cmd.op = req_valid ? OP_CAPTURE : OP_NONE;
            ST_DECODE:
            begin
                if (status.func == FUNC_WRITE_NODE)
                    cmd.op = OP_NODE_WR;
                else if (status.func == FUNC_FIND && status.query_ok)
                    cmd.op = status.same_node ? OP_SAME_WR : OP_CLR_INIT;
            end
            ST_APPEND:    cmd.op = OP_APPEND;
            ST_BUMP:      cmd.op = OP_BUMP;
            ST_PATH_LOAD: cmd.op = OP_PATH_LOAD;
            ST_CLEAR:     cmd.op = OP_CLR;
            ST_SEED:      cmd.op = OP_SEED;
            ST_POP:       cmd.op = OP_POP;
            ST_ULOAD:     cmd.op = OP_ULOAD;
            ST_EDGE_TAKE: cmd.op = status.v_out ? OP_EDGE_SKIP : OP_EDGE_TAKE;
            ST_EDGE_MUL:  cmd.op = OP_EDGE_MUL;
            ST_EDGE_ADD:  cmd.op = OP_EDGE_ADD;
            ST_EDGE_UPD:  cmd.op = OP_EDGE_UPD;
            ST_GOAL_CHK:  cmd.op = status.goal_valid ? OP_WALK_INIT : OP_NONE;
            ST_CNT:       cmd.op = OP_CNT;
            ST_CNT_LOAD:  cmd.op = OP_CNT_LOAD;
            ST_PW_INIT:   cmd.op = OP_PW_INIT;
            ST_PW:        cmd.op = OP_PW;
            ST_PW_LOAD:   cmd.op = OP_PW_LOAD;
            ST_RESP:      cmd.op = status.out_free ? OP_EMIT : OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

@@ sv/wsp_datapath.sv @@
// ----------------------------------------------------------------------------
// Waypoint shortest path datapath
// Graph, search and path memories with the cost pipeline and result register.
// ----------------------------------------------------------------------------
module wsp_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wsp_pkg::ctl_cmd_t   cmd,
    input  wsp_pkg::req_t       req_data,
    input  logic [9:0]          node_count,
    output wsp_pkg::dp_status_t status,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output wsp_pkg::rsp_t       rsp_data
);
    import wsp_pkg::*;

    typedef struct packed {
        logic               door;
        logic [1:0]         key;
        logic [VISIT_W-1:0] visit;
    } attr_t;

    typedef struct packed {
        logic [NODE_W-1:0] target;
        logic [10:0]       len;
    } edge_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
    } cost_t;

    // memories
    attr_t             attr_mem   [MAX_NODES];
    logic [FILL_W-1:0] fill_mem   [MAX_NODES];
    edge_t             edge_mem   [MAX_NODES*MAX_EDGES];
    cost_t             cost_mem   [MAX_NODES];
    logic              queued_mem [MAX_NODES];
    logic [NODE_W-1:0] cf_mem     [MAX_NODES];
    logic [NODE_W-1:0] queue_mem  [MAX_NODES];
    logic [NODE_W-1:0] path_mem   [MAX_NODES];

    // registered read data
    attr_t             attr_rd;
    logic [FILL_W-1:0] fill_rd;
    edge_t             edge_rd;
    cost_t             cost_rd;
    logic              queued_rd;
    logic [NODE_W-1:0] cf_rd;
    logic [NODE_W-1:0] queue_rd;
    logic [NODE_W-1:0] path_rd;

    // working registers
    req_t               req_reg;
    logic [NODE_W-1:0]  clr_reg;
    logic [NODE_W-1:0]  head_reg;
    logic [LEN_W-1:0]   used_reg;
    logic [NODE_W-1:0]  u_reg;
    logic [COST_W-1:0]  ucost_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  e_reg;
    logic [NODE_W-1:0]  v_reg;
    logic [10:0]        elen_reg;
    logic [VIS50_W-1:0] vis50_reg;
    logic               enter_reg;
    logic [COST_W-1:0]  vcost_reg;
    logic               vvalid_reg;
    logic               vqueued_reg;
    logic [COST_W-1:0]  c_reg;
    logic               upd_reg;
    logic [NODE_W-1:0]  cur_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   idx_reg;
    logic               found_reg;
    logic [NODE_W-1:0]  pnode_reg;
    logic               evalid_reg;
    logic [LEN_W-1:0]   stored_len_reg;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;

    logic [LEN_W-1:0]   lim;
    logic               append_ok;
    logic               enqueue;
    logic               may_enter;
    logic [COST_W+1:0]  sum;
    logic [COST_W-1:0]  sum_sat;
    logic [NODE_W-1:0]  tail;
    logic [NODE_W-1:0]  pw_addr;

    // effective node limit
    assign lim = (node_count > LEN_W'(MAX_NODES)) ? LEN_W'(MAX_NODES) : node_count;

    assign append_ok = (fill_rd < FILL_W'(MAX_EDGES));
    assign enqueue   = (cmd.op == OP_EDGE_UPD) && upd_reg && !vqueued_reg &&
                       (used_reg < LEN_W'(MAX_NODES));
    assign tail      = head_reg + used_reg[NODE_W-1:0];
    assign pw_addr   = idx_reg[NODE_W-1:0] - 1'b1;

    // door key check on the freshly read target attributes
    always_comb
    begin
        may_enter = 1'b1;
        if (attr_rd.door)
        begin
            case (attr_rd.key)
                KEY_BLUE:   may_enter = req_reg.held_keys[0];
                KEY_RED:    may_enter = req_reg.held_keys[1];
                KEY_YELLOW: may_enter = req_reg.held_keys[2];
                default:    may_enter = 1'b1;
            endcase
        end
    end

    // candidate cost, saturated to 32 bits
    assign sum     = {2'b00, ucost_reg} + {23'd0, elen_reg} + {12'd0, vis50_reg};
    assign sum_sat = (|sum[COST_W+1:COST_W]) ? '1 : sum[COST_W-1:0];

    // node attribute memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_NODE_WR)
            attr_mem[req_reg.node_index] <= '{req_reg.door_flag, req_reg.key_needed,
                                              req_reg.visit_init};
        else if (cmd.op == OP_BUMP)
            attr_mem[req_reg.node_index] <= '{attr_rd.door, attr_rd.key,
                (attr_rd.visit == '1) ? attr_rd.visit : attr_rd.visit + 1'b1};
        attr_rd <= attr_mem[(cmd.op == OP_EDGE_TAKE) ? edge_rd.target
                                                     : req_reg.node_index];
    end

    // edge fill memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_NODE_WR)
            fill_mem[req_reg.node_index] <= '0;
        else if (cmd.op == OP_APPEND && append_ok)
            fill_mem[req_reg.node_index] <= fill_rd + 1'b1;
        fill_rd <= fill_mem[(cmd.op == OP_POP) ? queue_rd : req_reg.node_index];
    end

    // edge list memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_APPEND && append_ok)
            edge_mem[{req_reg.node_index, fill_rd[3:0]}] <= '{req_reg.neighbor_index,
                                                              req_reg.edge_length};
        edge_rd <= edge_mem[{u_reg, e_reg[3:0]}];
    end

    // best cost memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLR)
            cost_mem[clr_reg] <= '0;
        else if (cmd.op == OP_SEED)
            cost_mem[req_reg.start_node] <= '{1'b1, '0};
        else if (cmd.op == OP_EDGE_UPD && upd_reg)
            cost_mem[v_reg] <= '{1'b1, c_reg};
        case (cmd.op)
            OP_POP:       cost_rd <= cost_mem[queue_rd];
            OP_EDGE_TAKE: cost_rd <= cost_mem[edge_rd.target];
            default:      cost_rd <= cost_mem[req_reg.goal_node];
        endcase
    end

    // queued mark memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLR)
            queued_mem[clr_reg] <= 1'b0;
        else if (cmd.op == OP_SEED)
            queued_mem[req_reg.start_node] <= 1'b1;
        else if (cmd.op == OP_POP)
            queued_mem[queue_rd] <= 1'b0;
        else if (enqueue)
            queued_mem[v_reg] <= 1'b1;
        queued_rd <= queued_mem[edge_rd.target];
    end

    // work queue ring
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SEED)
            queue_mem[0] <= req_reg.start_node;
        else if (enqueue)
            queue_mem[tail] <= v_reg;
        queue_rd <= queue_mem[head_reg];
    end

    // predecessor memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EDGE_UPD && upd_reg)
            cf_mem[v_reg] <= u_reg;
        cf_rd <= cf_mem[cur_reg];
    end

    // stored path memory
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SAME_WR)
            path_mem[0] <= req_reg.start_node;
        else if (cmd.op == OP_PW)
            path_mem[pw_addr] <= cur_reg;
        path_rd <= path_mem[req_reg.path_index];
    end

    // search and request working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                req_reg    <= req_data;
                found_reg  <= 1'b0;
                pnode_reg  <= '0;
                evalid_reg <= 1'b0;
            end
            OP_APPEND:    found_reg <= append_ok;
            OP_PATH_LOAD:
            begin
                evalid_reg <= ({1'b0, req_reg.path_index} < stored_len_reg);
                pnode_reg  <= ({1'b0, req_reg.path_index} < stored_len_reg) ? path_rd : '0;
            end
            OP_SAME_WR:   found_reg <= 1'b1;
            OP_CLR_INIT:  clr_reg <= '0;
            OP_CLR:       clr_reg <= clr_reg + 1'b1;
            OP_SEED:
            begin
                head_reg <= '0;
                used_reg <= LEN_W'(1);
            end
            OP_POP:
            begin
                u_reg    <= queue_rd;
                head_reg <= head_reg + 1'b1;
                used_reg <= used_reg - 1'b1;
            end
            OP_ULOAD:
            begin
                ucost_reg <= cost_rd.cost;
                fill_reg  <= (fill_rd > FILL_W'(MAX_EDGES)) ? FILL_W'(MAX_EDGES) : fill_rd;
                e_reg     <= '0;
            end
            OP_EDGE_SKIP: e_reg <= e_reg + 1'b1;
            OP_EDGE_TAKE:
            begin
                v_reg    <= edge_rd.target;
                elen_reg <= edge_rd.len;
            end
            OP_EDGE_MUL:
            begin
                vis50_reg   <= VIS50_W'(attr_rd.visit) * 6'(VISIT_WEIGHT);
                enter_reg   <= may_enter;
                vcost_reg   <= cost_rd.cost;
                vvalid_reg  <= cost_rd.valid;
                vqueued_reg <= queued_rd;
            end
            OP_EDGE_ADD:
            begin
                c_reg   <= sum_sat;
                upd_reg <= enter_reg && (!vvalid_reg || sum_sat < vcost_reg);
            end
            OP_EDGE_UPD:
            begin
                e_reg <= e_reg + 1'b1;
                if (enqueue)
                    used_reg <= used_reg + 1'b1;
            end
            OP_WALK_INIT:
            begin
                cur_reg <= req_reg.goal_node;
                len_reg <= '0;
            end
            OP_CNT:       len_reg <= len_reg + 1'b1;
            OP_CNT_LOAD:  cur_reg <= cf_rd;
            OP_PW_INIT:
            begin
                cur_reg <= req_reg.goal_node;
                idx_reg <= len_reg;
            end
            OP_PW:
            begin
                idx_reg <= idx_reg - 1'b1;
                if (idx_reg == LEN_W'(1))
                    found_reg <= 1'b1;
            end
            OP_PW_LOAD:   cur_reg <= cf_rd;
            default:      ;
        endcase
    end

    // stored path length and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_len_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_SAME_WR)
                stored_len_reg <= LEN_W'(1);
            else if (cmd.op == OP_PW && idx_reg == LEN_W'(1))
                stored_len_reg <= len_reg;
            if (cmd.op == OP_EMIT)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_EMIT)
            rsp_reg <= '{found_reg, stored_len_reg, pnode_reg, evalid_reg};
    end

    // status to controller
    assign status.func       = req_reg.func;
    assign status.query_ok   = ({1'b0, req_reg.start_node} < lim) &&
                               ({1'b0, req_reg.goal_node} < lim);
    assign status.same_node  = (req_reg.start_node == req_reg.goal_node);
    assign status.clr_last   = ({1'b0, clr_reg} == lim - 1'b1);
    assign status.q_empty    = (used_reg == '0);
    assign status.is_goal    = (queue_rd == req_reg.goal_node);
    assign status.edges_done = (e_reg == fill_reg);
    assign status.v_out      = ({1'b0, edge_rd.target} >= lim);
    assign status.goal_valid = cost_rd.valid;
    assign status.walk_stop  = (cur_reg == req_reg.start_node) ||
                               (len_reg == LEN_W'(MAX_NODES - 1));
    assign status.pw_last    = (idx_reg == LEN_W'(1));
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
